@@ rtl/core/lkvc_pkg.sv @@
package lkvc_pkg;

  localparam int unsigned ENTRIES_DEF  = 16;
  localparam int unsigned KEY_BITS_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned CAP_W        = 5;
  localparam int unsigned CAP_RESET    = 16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

@@ rtl/core/lru_key_value_cache_unit.sv @@
// Fully associative key-value cache with least-recently-used replacement. Keys and values
// sit in two synchronous memories with one read and one write port; valid bits and recency
// ranks (0 is the most recent) sit in flip-flops that reset clears. A request is a get
// (func_i = 0) or a put (func_i = 1) and yields exactly one response: hit_o tells whether the
// key was present, read_value_o carries the stored value on a get hit and zero otherwise.
// Each request walks the key memory one entry per cycle: a read per entry through the
// memory port, then a drain of the read data, then an update step, then a return to idle
// for the handshake; a new request is accepted only in idle. The update step waits while an
// earlier response has not been taken. No clearing pass is needed after reset. capacity
// (cfg_wdata_i, reset 16) limits the number of live entries; zero acts as one and values
// above ENTRIES act as ENTRIES. Write it only while idle.
module lru_key_value_cache_unit
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES  = ENTRIES_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CAP_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [KEY_BITS-1:0]       key_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic signed [VALUE_W-1:0] read_value_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned RANK_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CAPW   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_e state_q, state_d;

  logic [CAP_W-1:0]   cap_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [RANK_W-1:0]  rank_q [ENTRIES];
  logic [RANK_W-1:0]  rank_d [ENTRIES];

  // Request held for the duration of the walk
  logic                func_q;
  logic [KEY_BITS-1:0] key_q;
  logic [VALUE_W-1:0]  value_q;
  logic                evict_q;

  // Walk state
  logic [IDX_W:0]      cnt_q;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    proc_idx;
  logic                found_q;
  logic [IDX_W-1:0]    hidx_q;
  logic [RANK_W-1:0]   hrank_q;
  logic [VALUE_W-1:0]  hval_q;
  logic                slot_found_q;
  logic [IDX_W-1:0]    slot_q;

  // Memories
  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [VALUE_W-1:0]  val_mem [ENTRIES];
  logic [KEY_BITS-1:0] key_rd_q;
  logic [VALUE_W-1:0]  val_rd_q;
  logic                mem_we;
  logic [IDX_W-1:0]    wr_idx;

  // Response register
  logic                out_valid_q;
  logic                hit_q;
  logic [VALUE_W-1:0]  rv_q;

  logic [CAPW-1:0]     eff_cap;
  logic [RANK_W-1:0]   capm1;
  logic                in_acc;
  logic                upd_go;
  logic                scan_proc;
  logic                scan_last;

  always_comb begin
    eff_cap = CAPW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CAPW'(1);
    end else if (CAPW'(cap_q) > CAPW'(ENTRIES)) begin
      eff_cap = CAPW'(ENTRIES);
    end
  end

  assign capm1 = RANK_W'(eff_cap - CAPW'(1));

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign upd_go     = (state_q == ST_UPDATE) && (!out_valid_q || out_ready_i);
  assign scan_proc  = (state_q == ST_SCAN) && (cnt_q != '0);
  assign scan_last  = (cnt_q == (IDX_W + 1)'(ENTRIES));
  assign rd_addr    = cnt_q[IDX_W-1:0];
  assign proc_idx   = IDX_W'(cnt_q - (IDX_W + 1)'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CAP_W'(CAP_RESET);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= func_i;
      key_q   <= key_i;
      value_q <= value_i;
      evict_q <= (CAPW'(count_q) >= eff_cap);
    end
  end

  // Walk over the entries: issue a read per cycle, examine the registered data in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      found_q      <= 1'b0;
      slot_found_q <= 1'b0;
    end else if (in_acc) begin
      cnt_q        <= '0;
      found_q      <= 1'b0;
      slot_found_q <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      if (!scan_last) begin
        cnt_q <= cnt_q + (IDX_W + 1)'(1);
      end
      if (scan_proc) begin
        if (!found_q && valid_q[proc_idx] && key_rd_q == key_q) begin
          found_q <= 1'b1;
        end
        if (!slot_found_q &&
            (!valid_q[proc_idx] || (evict_q && rank_q[proc_idx] >= capm1))) begin
          slot_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_proc) begin
      if (!found_q && valid_q[proc_idx] && key_rd_q == key_q) begin
        hidx_q  <= proc_idx;
        hrank_q <= rank_q[proc_idx];
        hval_q  <= val_rd_q;
      end
      if (!slot_found_q &&
          (!valid_q[proc_idx] || (evict_q && rank_q[proc_idx] >= capm1))) begin
        slot_q <= proc_idx;
      end
    end
  end

  assign mem_we = upd_go && (func_q == FUNC_PUT);
  assign wr_idx = found_q ? hidx_q : slot_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[wr_idx] <= key_q;
      val_mem[wr_idx] <= value_q;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  // Recency and occupancy update, applied to all entries in the update cycle
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < int'(ENTRIES); i++) begin
      rank_d[i] = rank_q[i];
    end
    if (upd_go) begin
      if (found_q) begin
        for (int i = 0; i < int'(ENTRIES); i++) begin
          if (valid_q[i] && rank_q[i] < hrank_q) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
          if (IDX_W'(i) == hidx_q) begin
            rank_d[i] = '0;
          end
        end
      end else if (func_q == FUNC_PUT) begin
        for (int i = 0; i < int'(ENTRIES); i++) begin
          if (evict_q && valid_q[i] && rank_q[i] >= capm1) begin
            valid_d[i] = 1'b0;
            rank_d[i]  = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
          if (IDX_W'(i) == slot_q) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end
        end
        // ranks are distinct, so eviction leaves capacity-1 entries before the insert
        count_d = evict_q ? CNT_W'(eff_cap) : count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < int'(ENTRIES); i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < int'(ENTRIES); i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Response register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      hit_q <= found_q;
      rv_q  <= (found_q && func_q == FUNC_GET) ? hval_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rv_q;

`ifndef NO_ASSERTIONS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count disagrees with valid bits");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= int'(ENTRIES))
    else $error("entry count above number of entries");

  a_put_miss_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && func_q == FUNC_PUT && !found_q) |-> slot_found_q)
    else $error("put miss without a free slot");

  a_resp_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPDATE))
    else $error("response raised outside the update cycle");
`endif

endmodule
